[rtl/obb_overlap_test_core_macros.svh]
// Assertion macros used by the RTL in obb_overlap_test_core.
`ifndef OBB_OVERLAP_TEST_CORE_MACROS_SVH
`define OBB_OVERLAP_TEST_CORE_MACROS_SVH
`define OBB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/obb_pkg.sv]
`default_nettype none
package obb_pkg;
	localparam int W = 16;
	localparam int F = W - 2;
	localparam int DW = W + 1;          // difference width
	localparam int CW = DW + W + 2;     // cen width (sum of 3 products)
	localparam int OW = 2 * W + 2;      // ori width
	localparam int NS = 6;              // pipeline stages
	typedef logic signed [W-1:0] comp_t;
	typedef logic signed [CW-1:0] cen_t;
	typedef logic signed [OW-1:0] ori_t;
	typedef logic signed [127:0] wide_t;
endpackage
`default_nettype wire

[rtl/obb_overlap_test_core.sv]
// Channel  Dir  tdata                                               tuser
// s_axis   in   extent_a,extent_b,basis_a_row0..2,origin_a,          none
//               basis_b_row0..2,origin_b (48 bits each, lowest first)
// m_axis   out  overlap                                             none
// One item per cycle when the output is taken, through six register stages.
// All stages advance together; a stall of the output holds every stage,
// so no item is lost or repeated. Reset clears valid bits.
`default_nettype none
`include "obb_overlap_test_core_macros.svh"
module obb_overlap_test_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [479:0] s_axis_tdata,  // extent_a..origin_b, 48 bits each
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [7:0]        m_axis_tdata   // overlap in bit 0
);
	localparam int W = obb_pkg::W;
	localparam int F = obb_pkg::F;
	localparam int OW = obb_pkg::OW;
	localparam int CW = obb_pkg::CW;
	localparam int PW = CW + OW;  // cen times ori
	localparam int QW = W + OW;   // extent times |ori|

	logic [obb_pkg::NS-1:0] v_q;
	logic adv;
	assign adv = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = v_q[obb_pkg::NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[obb_pkg::NS-2:0], s_axis_tvalid};
	end

	function automatic obb_pkg::comp_t fld(input logic [479:0] d, input int f, input int c);
		fld = d[f*48 + c*W +: W];
	endfunction

	function automatic obb_pkg::ori_t mag(input obb_pkg::ori_t v);
		mag = (v < 0) ? -v : v;
	endfunction

	function automatic obb_pkg::wide_t mul_co(input obb_pkg::cen_t c, input obb_pkg::ori_t o);
		logic signed [PW-1:0] p;
		p = c * o;
		mul_co = obb_pkg::wide_t'(p);
	endfunction

	// Extent times a magnitude, brought to 4F fraction bits.
	function automatic obb_pkg::wide_t mul_eo(input obb_pkg::comp_t e, input obb_pkg::ori_t m);
		logic signed [QW-1:0] p;
		p = e * m;
		mul_eo = obb_pkg::wide_t'(p) <<< F;
	endfunction

	// stage 1: unpack, origin difference
	obb_pkg::comp_t a_s1[3], b_s1[3], ra_s1[3][3], rb_s1[3][3];
	logic signed [obb_pkg::DW-1:0] d_s1[3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= fld(s_axis_tdata, 0, k);
				b_s1[k] <= fld(s_axis_tdata, 1, k);
				d_s1[k] <= obb_pkg::DW'(fld(s_axis_tdata, 9, k))
					- obb_pkg::DW'(fld(s_axis_tdata, 5, k));
				for (int j = 0; j < 3; j++) begin
					ra_s1[k][j] <= fld(s_axis_tdata, 2 + k, j);
					rb_s1[k][j] <= fld(s_axis_tdata, 6 + k, j);
				end
			end
		end
	end

	// stage 2: cen and ori as sums of three products
	obb_pkg::cen_t cen_s2[3];
	obb_pkg::ori_t ori_s2[3][3];
	obb_pkg::comp_t a_s2[3], b_s2[3];
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			for (int i = 0; i < 3; i++) begin
				cen_s2[i] <= CW'(ra_s1[0][i] * d_s1[0]) + CW'(ra_s1[1][i] * d_s1[1])
					+ CW'(ra_s1[2][i] * d_s1[2]);
				for (int j = 0; j < 3; j++)
					ori_s2[i][j] <= OW'(rb_s1[0][i] * ra_s1[0][j])
						+ OW'(rb_s1[1][i] * ra_s1[1][j]) + OW'(rb_s1[2][i] * ra_s1[2][j]);
			end
		end
	end

	// stage 3: products of cen with ori, and extents with |ori|
	obb_pkg::wide_t pc_s3[3][3];  // cen[j]*ori[i][j]
	obb_pkg::wide_t pa_s3[3][3];  // a[j]*|ori[i][j]|
	obb_pkg::wide_t pb_s3[3][3];  // b[i]*|ori[i][j]|
	// Edge axis A_j x B_i: the two cross terms of cen and the four bound terms.
	obb_pkg::wide_t xl_s3[3][3], xr_s3[3][3];
	obb_pkg::wide_t ua_s3[3][3], va_s3[3][3], ub_s3[3][3], vb_s3[3][3];
	obb_pkg::wide_t cen_s3[3], ea_s3[3], eb_s3[3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cen_s3[i] <= 128'(cen_s2[i]) <<< (2 * F);
				ea_s3[i] <= 128'(a_s2[i]) <<< (3 * F);
				eb_s3[i] <= 128'(b_s2[i]) <<< (3 * F);
				for (int j = 0; j < 3; j++) begin
					pc_s3[i][j] <= mul_co(cen_s2[j], ori_s2[i][j]);
					pa_s3[i][j] <= mul_eo(a_s2[j], mag(ori_s2[i][j]));
					pb_s3[i][j] <= mul_eo(b_s2[i], mag(ori_s2[i][j]));
					xl_s3[i][j] <= mul_co(cen_s2[(j+2)%3], ori_s2[i][(j+1)%3]);
					xr_s3[i][j] <= mul_co(cen_s2[(j+1)%3], ori_s2[i][(j+2)%3]);
					ua_s3[i][j] <= mul_eo(a_s2[(j+1)%3], mag(ori_s2[i][(j+2)%3]));
					va_s3[i][j] <= mul_eo(a_s2[(j+2)%3], mag(ori_s2[i][(j+1)%3]));
					ub_s3[i][j] <= mul_eo(b_s2[(i+1)%3], mag(ori_s2[(i+2)%3][j]));
					vb_s3[i][j] <= mul_eo(b_s2[(i+2)%3], mag(ori_s2[(i+1)%3][j]));
				end
			end
		end
	end

	// stage 4: signed left sides and bound sums
	obb_pkg::wide_t lf_s4[15], rf_s4[15];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				lf_s4[i] <= cen_s3[i];
				rf_s4[i] <= ea_s3[i] + pb_s3[0][i] + pb_s3[1][i] + pb_s3[2][i];
				lf_s4[3+i] <= pc_s3[i][0] + pc_s3[i][1] + pc_s3[i][2];
				rf_s4[3+i] <= eb_s3[i] + pa_s3[i][0] + pa_s3[i][1] + pa_s3[i][2];
				for (int j = 0; j < 3; j++) begin
					lf_s4[6+3*i+j] <= xl_s3[i][j] - xr_s3[i][j];
					rf_s4[6+3*i+j] <= ua_s3[i][j] + va_s3[i][j]
						+ ub_s3[i][j] + vb_s3[i][j];
				end
			end
		end
	end

	// stage 5: per-axis separation compare
	logic [14:0] sep_s5;
	always_ff @(posedge clk) begin
		if (adv)
			for (int t = 0; t < 15; t++)
				sep_s5[t] <= (lf_s4[t] < 0 ? -lf_s4[t] : lf_s4[t]) > rf_s4[t];
	end

	// stage 6: output register
	logic ov_s6;
	always_ff @(posedge clk) begin
		if (adv) ov_s6 <= ~|sep_s5;
	end
	assign m_axis_tdata = {7'd0, ov_s6};

	`OBB_ASSERT_IMPL(a_ready, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
		"ready while output stalled")
	`OBB_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
	`OBB_ASSERT_IMPL(a_pad, 1'b1, m_axis_tdata[7:1] == 7'd0, "padding not zero")
endmodule
`default_nettype wire
